// ===== design/kvt_pkg.sv =====
// Shared types and constants for the keyframe vertex transform.
`timescale 1ns / 1ps
`default_nettype none

package kvt_pkg;

  // Configuration write port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_SCALE       = 3'd0,
    REG_KEY_ROTATION    = 3'd1,
    REG_KEY_TRANSLATION = 3'd2,
    REG_NODE_ROW_FIRST  = 3'd3,
    REG_NODE_ROW_SECOND = 3'd4,
    REG_NODE_ROW_THIRD  = 3'd5
  } cfg_reg_t;

  // Register widths
  localparam int KEY_SCALE_W = 48;
  localparam int KEY_ROT_W   = 64;
  localparam int KEY_TRANS_W = 48;
  localparam int NODE_ROW_W  = 64;

  // Reset contents: unit scale, identity rotation, zero translation, identity node
  localparam logic [KEY_SCALE_W-1:0] KEY_SCALE_RST = 48'h1000_1000_1000;
  localparam logic [KEY_ROT_W-1:0]   KEY_ROT_RST   = 64'h0000_0000_0000_1000;
  localparam logic [KEY_TRANS_W-1:0] KEY_TRANS_RST = 48'h0;
  localparam logic [NODE_ROW_W-1:0]  NODE_ROW0_RST = 64'h0000_0000_0000_1000;
  localparam logic [NODE_ROW_W-1:0]  NODE_ROW1_RST = 64'h0000_0000_1000_0000;
  localparam logic [NODE_ROW_W-1:0]  NODE_ROW2_RST = 64'h0000_1000_0000_0000;

endpackage

`default_nettype wire

// ===== design/kvt_cfg_if.sv =====
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps
`default_nettype none

interface kvt_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [kvt_pkg::CFG_IDX_W-1:0]  index;
  logic [kvt_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/kvt_in_if.sv =====
// Input vertex channel.
`timescale 1ns / 1ps
`default_nettype none

interface kvt_in_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] in_x;
  logic signed [COORD_WIDTH-1:0] in_y;
  logic signed [COORD_WIDTH-1:0] in_z;

  modport source (output valid, output in_x, output in_y, output in_z, input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

`default_nettype wire

// ===== design/kvt_out_if.sv =====
// Result vertex channel with saturation flag.
`timescale 1ns / 1ps
`default_nettype none

interface kvt_out_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic signed [COORD_WIDTH-1:0] out_z;
  logic                          saturated;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output saturated, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z,
                  input saturated, output ready);
endinterface

`default_nettype wire

// ===== design/keyframe_vertex_transform.sv =====
// Keyframe vertex transform: scale, quaternion rotate, node affine, translate, negate x and swap y and z.
// Six-stage pipeline taking one vertex per clock while the output side is not stalled; a
// result is presented from the output register of the last stage and transfers when the
// output side is ready. Stages alternate between a
// multiplier bank (scale and quaternion products, rotation products, node products)
// and a sum, round-half-up and clamp step, so each stage holds one multiply or one
// add-and-compare. Every stage has its own valid bit and ready, so bubbles are
// squeezed out and a stalled output only holds back the stages that are full.
// Configuration writes are taken at any time on a ready-always port but must only be
// issued while no vertex is in flight. Results saturate to the coordinate range and
// the saturated flag reports any clamp along the way for that vertex.
`timescale 1ns / 1ps
`default_nettype none

module keyframe_vertex_transform #(
  parameter int COORD_WIDTH = 16,
  parameter int COEF_WIDTH  = 16
) (
  input  wire        clk,
  input  wire        rst_n,
  kvt_cfg_if.sink    cfg_wr,
  kvt_in_if.sink     in_vtx,
  kvt_out_if.source  out_vtx
);

  localparam int CW   = COORD_WIDTH;
  localparam int KW   = COEF_WIDTH;
  localparam int CF   = KW - 4;
  localparam int PW   = CW + KW;           // coordinate by coefficient product
  localparam int QPW  = 2 * KW;            // quaternion product
  localparam int LW   = 2 * KW + CW + 8;   // working width for sums, rounding, clamps
  localparam int EXTW = 64 + 4 * (KW + CW);
  localparam int NST  = 6;

  localparam logic signed [LW-1:0] ONE_L = LW'(1) <<< (2 * CF);
  localparam logic signed [LW-1:0] HALF  = LW'(1) <<< (CF - 1);
  localparam logic signed [LW-1:0] C_MAX = (LW'(1) <<< (CW - 1)) - LW'(1);
  localparam logic signed [LW-1:0] C_MIN = -(LW'(1) <<< (CW - 1));
  localparam logic signed [LW-1:0] K_MAX = (LW'(1) <<< (KW - 1)) - LW'(1);
  localparam logic signed [LW-1:0] K_MIN = -(LW'(1) <<< (KW - 1));

  // Round half up at CF fraction bits
  function automatic logic signed [LW-1:0] rnd_f(input logic signed [LW-1:0] v);
    rnd_f = (v + HALF) >>> CF;
  endfunction

  // Clamp to coordinate range; top bit is the clamp flag
  function automatic logic [CW:0] clamp_c(input logic signed [LW-1:0] v);
    if (v > C_MAX) begin
      clamp_c = {1'b1, C_MAX[CW-1:0]};
    end else if (v < C_MIN) begin
      clamp_c = {1'b1, C_MIN[CW-1:0]};
    end else begin
      clamp_c = {1'b0, v[CW-1:0]};
    end
  endfunction

  // Clamp to coefficient range; top bit is the clamp flag
  function automatic logic [KW:0] clamp_k(input logic signed [LW-1:0] v);
    if (v > K_MAX) begin
      clamp_k = {1'b1, K_MAX[KW-1:0]};
    end else if (v < K_MIN) begin
      clamp_k = {1'b1, K_MIN[KW-1:0]};
    end else begin
      clamp_k = {1'b0, v[KW-1:0]};
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [kvt_pkg::KEY_SCALE_W-1:0] key_scale_r;
  logic [kvt_pkg::KEY_ROT_W-1:0]   key_rot_r;
  logic [kvt_pkg::KEY_TRANS_W-1:0] key_trans_r;
  logic [kvt_pkg::NODE_ROW_W-1:0]  node_row_r [3];

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_scale_r   <= kvt_pkg::KEY_SCALE_RST;
      key_rot_r     <= kvt_pkg::KEY_ROT_RST;
      key_trans_r   <= kvt_pkg::KEY_TRANS_RST;
      node_row_r[0] <= kvt_pkg::NODE_ROW0_RST;
      node_row_r[1] <= kvt_pkg::NODE_ROW1_RST;
      node_row_r[2] <= kvt_pkg::NODE_ROW2_RST;
    end else if (cfg_wr.valid) begin
      case (kvt_pkg::cfg_reg_t'(cfg_wr.index))
        kvt_pkg::REG_KEY_SCALE:       key_scale_r   <= cfg_wr.data[kvt_pkg::KEY_SCALE_W-1:0];
        kvt_pkg::REG_KEY_ROTATION:    key_rot_r     <= cfg_wr.data[kvt_pkg::KEY_ROT_W-1:0];
        kvt_pkg::REG_KEY_TRANSLATION: key_trans_r   <= cfg_wr.data[kvt_pkg::KEY_TRANS_W-1:0];
        kvt_pkg::REG_NODE_ROW_FIRST:  node_row_r[0] <= cfg_wr.data[kvt_pkg::NODE_ROW_W-1:0];
        kvt_pkg::REG_NODE_ROW_SECOND: node_row_r[1] <= cfg_wr.data[kvt_pkg::NODE_ROW_W-1:0];
        kvt_pkg::REG_NODE_ROW_THIRD:  node_row_r[2] <= cfg_wr.data[kvt_pkg::NODE_ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Lane unpacking; bits beyond a register read as zero
  logic [EXTW-1:0]        scl_ext, rot_ext, trn_ext;
  logic [EXTW-1:0]        row_ext [3];
  logic signed [KW-1:0]   scale_k [3];
  logic signed [KW-1:0]   quat_k [4];
  logic signed [CW-1:0]   trans_c [3];
  logic signed [KW-1:0]   node_k [3][3];
  logic signed [CW-1:0]   node_off [3];

  always_comb begin
    scl_ext = {{(EXTW - kvt_pkg::KEY_SCALE_W){1'b0}}, key_scale_r};
    rot_ext = {{(EXTW - kvt_pkg::KEY_ROT_W){1'b0}}, key_rot_r};
    trn_ext = {{(EXTW - kvt_pkg::KEY_TRANS_W){1'b0}}, key_trans_r};
    for (int i = 0; i < 3; i++) begin
      row_ext[i]  = {{(EXTW - kvt_pkg::NODE_ROW_W){1'b0}}, node_row_r[i]};
      scale_k[i]  = $signed(scl_ext[i*KW +: KW]);
      trans_c[i]  = $signed(trn_ext[i*CW +: CW]);
      node_off[i] = $signed(row_ext[i][3*KW +: CW]);
      for (int j = 0; j < 3; j++) begin
        node_k[i][j] = $signed(row_ext[i][j*KW +: KW]);
      end
    end
    for (int q = 0; q < 4; q++) begin
      quat_k[q] = $signed(rot_ext[q*KW +: KW]);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage handshake: each stage loads when empty or when the next one moves on
  logic [NST-1:0] vld_r, vld_nxt, rdy, vin, ld;

  always_comb begin
    vin = {vld_r[NST-2:0], in_vtx.valid};
    rdy[NST-1] = !vld_r[NST-1] || out_vtx.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    for (int k = 0; k < NST; k++) begin
      vld_nxt[k] = rdy[k] ? vin[k] : vld_r[k];
    end
    ld = rdy & vin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_vtx.ready = rdy[0];

  // ---------------------------------------------------------------------------
  // Stage 1: axis scale products and quaternion products
  logic signed [CW-1:0]  in_c [3];
  logic signed [PW-1:0]  sp_r [3];
  logic signed [QPW-1:0] qp_r [9];   // xx yy zz xy xz yz xw yw zw

  assign in_c[0] = in_vtx.in_x;
  assign in_c[1] = in_vtx.in_y;
  assign in_c[2] = in_vtx.in_z;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int j = 0; j < 3; j++) begin
        sp_r[j] <= PW'(in_c[j]) * PW'(scale_k[j]);
      end
      qp_r[0] <= QPW'(quat_k[1]) * QPW'(quat_k[1]);
      qp_r[1] <= QPW'(quat_k[2]) * QPW'(quat_k[2]);
      qp_r[2] <= QPW'(quat_k[3]) * QPW'(quat_k[3]);
      qp_r[3] <= QPW'(quat_k[1]) * QPW'(quat_k[2]);
      qp_r[4] <= QPW'(quat_k[1]) * QPW'(quat_k[3]);
      qp_r[5] <= QPW'(quat_k[2]) * QPW'(quat_k[3]);
      qp_r[6] <= QPW'(quat_k[1]) * QPW'(quat_k[0]);
      qp_r[7] <= QPW'(quat_k[2]) * QPW'(quat_k[0]);
      qp_r[8] <= QPW'(quat_k[3]) * QPW'(quat_k[0]);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: scaled vector and rotation matrix, rounded and clamped
  logic signed [LW-1:0] xx, yy, zz, xy, xz, yz, xw, yw, zw;
  logic signed [LW-1:0] mraw [9];
  logic [CW:0]          p_cl [3];
  logic [KW:0]          m_cl [9];
  logic                 f2_nxt;
  logic signed [CW-1:0] p_r [3];
  logic signed [KW-1:0] m_r [9];
  logic                 f2_r;

  always_comb begin
    xx = LW'(qp_r[0]);
    yy = LW'(qp_r[1]);
    zz = LW'(qp_r[2]);
    xy = LW'(qp_r[3]);
    xz = LW'(qp_r[4]);
    yz = LW'(qp_r[5]);
    xw = LW'(qp_r[6]);
    yw = LW'(qp_r[7]);
    zw = LW'(qp_r[8]);
    mraw[0] = ONE_L - ((yy + zz) <<< 1);
    mraw[1] = (xy - zw) <<< 1;
    mraw[2] = (xz + yw) <<< 1;
    mraw[3] = (xy + zw) <<< 1;
    mraw[4] = ONE_L - ((xx + zz) <<< 1);
    mraw[5] = (yz - xw) <<< 1;
    mraw[6] = (xz - yw) <<< 1;
    mraw[7] = (yz + xw) <<< 1;
    mraw[8] = ONE_L - ((xx + yy) <<< 1);
    f2_nxt = 1'b0;
    for (int j = 0; j < 3; j++) begin
      p_cl[j] = clamp_c(rnd_f(LW'(sp_r[j])));
      f2_nxt  = f2_nxt | p_cl[j][CW];
    end
    for (int e = 0; e < 9; e++) begin
      m_cl[e] = clamp_k(rnd_f(mraw[e]));
      f2_nxt  = f2_nxt | m_cl[e][KW];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      for (int j = 0; j < 3; j++) begin
        p_r[j] <= $signed(p_cl[j][CW-1:0]);
      end
      for (int e = 0; e < 9; e++) begin
        m_r[e] <= $signed(m_cl[e][KW-1:0]);
      end
      f2_r <= f2_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: rotation products
  logic signed [PW-1:0] mp_r [9];
  logic                 f3_r;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          mp_r[3*i+j] <= PW'(m_r[3*i+j]) * PW'(p_r[j]);
        end
      end
      f3_r <= f2_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: rotated vector, rounded and clamped
  logic [CW:0]          r_cl [3];
  logic                 f4_nxt;
  logic signed [CW-1:0] r_r [3];
  logic                 f4_r;

  always_comb begin
    f4_nxt = f3_r;
    for (int i = 0; i < 3; i++) begin
      r_cl[i] = clamp_c(rnd_f(LW'(mp_r[3*i]) + LW'(mp_r[3*i+1]) + LW'(mp_r[3*i+2])));
      f4_nxt  = f4_nxt | r_cl[i][CW];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      for (int i = 0; i < 3; i++) begin
        r_r[i] <= $signed(r_cl[i][CW-1:0]);
      end
      f4_r <= f4_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: node matrix products
  logic signed [PW-1:0] cr_r [9];
  logic                 f5_r;

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          cr_r[3*i+j] <= PW'(node_k[i][j]) * PW'(r_r[j]);
        end
      end
      f5_r <= f4_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: add offsets, round, negate x, swap y and z, clamp into output register
  logic signed [LW-1:0] off_l [3];
  logic signed [LW-1:0] v_l [3];
  logic [CW:0]          ox_cl, oy_cl, oz_cl;
  logic signed [CW-1:0] ox_r, oy_r, oz_r;
  logic                 sat_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      off_l[i] = (LW'(node_off[i]) + LW'(trans_c[i])) <<< CF;
      v_l[i]   = rnd_f(LW'(cr_r[3*i]) + LW'(cr_r[3*i+1]) + LW'(cr_r[3*i+2]) + off_l[i]);
    end
    ox_cl = clamp_c(-v_l[0]);
    oy_cl = clamp_c(v_l[2]);
    oz_cl = clamp_c(v_l[1]);
  end

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      ox_r  <= $signed(ox_cl[CW-1:0]);
      oy_r  <= $signed(oy_cl[CW-1:0]);
      oz_r  <= $signed(oz_cl[CW-1:0]);
      sat_r <= f5_r | ox_cl[CW] | oy_cl[CW] | oz_cl[CW];
    end
  end

  assign out_vtx.valid     = vld_r[NST-1];
  assign out_vtx.out_x     = ox_r;
  assign out_vtx.out_y     = oy_r;
  assign out_vtx.out_z     = oz_r;
  assign out_vtx.saturated = sat_r;

  // ---------------------------------------------------------------------------
  // Checks

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> (vld_r == '0))
    else $error("pipeline stage valid after reset");

  // a full stage that could not move on still holds its vertex
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (($past(vld_r) & ~$past(rdy) & ~vld_r) == '0))
    else $error("stalled stage dropped its vertex");

  // a completely full pipeline with a stalled output takes no new vertex
  a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    ((&vld_r) && !out_vtx.ready) |-> !in_vtx.ready)
    else $error("input accepted while pipeline full and stalled");

  // a vertex accepted at the input makes the first stage valid next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    in_vtx.valid && in_vtx.ready |=> vld_r[0])
    else $error("first stage lost an accepted vertex");

endmodule

`default_nettype wire
